@@ rtl/core/prd_pkg.sv @@
// ----------------------------------------------------------------------------
// Packet route decision package
// Beat types, function and verdict codes, and default parameter values shared
// by the route decision modules.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

  localparam int unsigned DEF_PORT_BASE    = 1;
  localparam int unsigned DEF_PORT_COUNT   = 31;
  localparam int unsigned DEF_LOGICAL_BASE = 32;
  localparam int unsigned DEF_ROUTE_COUNT  = 224;

  localparam int unsigned MASK_W = 31;

  typedef enum logic [1:0] {
    FUNC_ROUTE    = 2'd0,
    FUNC_ROUTE_WR = 2'd1,
    FUNC_PORT_WR  = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    VERDICT_FORWARD = 3'd0,
    VERDICT_WAIT    = 3'd1,
    VERDICT_EMPTY   = 3'd2,
    VERDICT_INVALID = 3'd3,
    VERDICT_NOROUTE = 3'd4,
    VERDICT_NOPORT  = 3'd5,
    VERDICT_BACKLOG = 3'd6,
    VERDICT_TOOLONG = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [7:0]        first_byte;
    logic [15:0]       packet_length;
    logic              more_waiting;
    logic [MASK_W-1:0] ready_mask;
    logic [4:0]        port_field;
    logic              route_pop;
    logic              entry_enable;
    logic [15:0]       port_max_len;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [4:0]  out_port;
    logic [15:0] out_length;
    logic        popped;
  } out_beat_t;

  // Packet header after the route store read.
  typedef struct packed {
    logic              vld;
    logic [7:0]        dest;
    logic [15:0]       len;
    logic              more;
    logic [MASK_W-1:0] mask;
    logic              rt_ok;
    logic              rt_pop;
    logic [4:0]        rt_port;
  } lookup_t;

endpackage

`default_nettype wire

@@ rtl/core/prd_route_lookup.sv @@
// ----------------------------------------------------------------------------
// Route lookup
// Holds the route store, takes route writes and reads the entry selected by a
// logical address, one beat per cycle while adv_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_route_lookup #(
  parameter int unsigned LOGICAL_BASE = prd_pkg::DEF_LOGICAL_BASE,
  parameter int unsigned ROUTE_COUNT  = prd_pkg::DEF_ROUTE_COUNT
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             acc_i,
  input  wire prd_pkg::in_beat_t in_data_i,
  output prd_pkg::lookup_t      lkp_o
);
  import prd_pkg::*;

  localparam int unsigned RIDX_W = (ROUTE_COUNT > 1) ? $clog2(ROUTE_COUNT) : 1;

  logic [6:0]             mem [ROUTE_COUNT];
  logic [ROUTE_COUNT-1:0] ent_vld_q;

  logic [8:0]        diff;
  logic              in_rng;
  logic [RIDX_W-1:0] idx;
  logic              wr_en;

  logic              vld_q;
  logic [7:0]        dest_q;
  logic [15:0]       len_q;
  logic              more_q;
  logic [MASK_W-1:0] mask_q;
  logic [6:0]        rdata_q;
  logic              hit_q;

  assign diff   = {1'b0, in_data_i.first_byte} - 9'(LOGICAL_BASE);
  assign in_rng = ({1'b0, in_data_i.first_byte} >= 9'(LOGICAL_BASE)) &&
                  (diff < 9'(ROUTE_COUNT));
  assign idx    = in_rng ? diff[RIDX_W-1:0] : '0;
  assign wr_en  = acc_i && (in_data_i.func == FUNC_ROUTE_WR) && in_rng;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx] <= {in_data_i.entry_enable, in_data_i.route_pop, in_data_i.port_field};
    end
    if (adv_i) begin
      rdata_q <= mem[idx];
      dest_q  <= in_data_i.first_byte;
      len_q   <= in_data_i.packet_length;
      more_q  <= in_data_i.more_waiting;
      mask_q  <= in_data_i.ready_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      vld_q     <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[idx] <= 1'b1;
      end
      if (adv_i) begin
        vld_q <= acc_i && (in_data_i.func == FUNC_ROUTE);
        hit_q <= in_rng && ent_vld_q[idx];
      end
    end
  end

  always_comb begin
    lkp_o.vld     = vld_q;
    lkp_o.dest    = dest_q;
    lkp_o.len     = len_q;
    lkp_o.more    = more_q;
    lkp_o.mask    = mask_q;
    lkp_o.rt_ok   = hit_q && rdata_q[6];
    lkp_o.rt_pop  = rdata_q[5];
    lkp_o.rt_port = rdata_q[4:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/prd_port_check.sv @@
// ----------------------------------------------------------------------------
// Port check
// Resolves the target port, reads the port store and forms the verdict.
// Also takes port writes.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_port_check #(
  parameter int unsigned PORT_BASE    = prd_pkg::DEF_PORT_BASE,
  parameter int unsigned PORT_COUNT   = prd_pkg::DEF_PORT_COUNT,
  parameter int unsigned LOGICAL_BASE = prd_pkg::DEF_LOGICAL_BASE
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              acc_i,
  input  wire prd_pkg::in_beat_t  in_data_i,
  input  wire prd_pkg::lookup_t   lkp_i,
  output logic                   res_vld_o,
  output prd_pkg::out_beat_t     res_o
);
  import prd_pkg::*;

  localparam int unsigned PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  logic [16:0]           mem [PORT_COUNT];
  logic [PORT_COUNT-1:0] ent_vld_q;

  // Port writes.
  logic [5:0]        wr_diff;
  logic              wr_rng;
  logic [PIDX_W-1:0] wr_idx;
  logic              wr_en;

  // Header resolution.
  logic              logical;
  logic              early;
  verdict_e          early_v;
  logic              pop;
  logic [7:0]        port8;
  logic [8:0]        p_diff;
  logic              p_rng;
  logic [PIDX_W-1:0] p_idx;
  logic [15:0]       newlen;

  logic              vld_q;
  logic              early_q;
  verdict_e          early_v_q;
  logic [4:0]        port_q;
  logic [15:0]       newlen_q;
  logic              pop_q;
  logic              p_rng_q;
  logic              more_q;
  logic              rdy_q;
  logic [16:0]       pdata_q;
  logic              pent_vld_q;

  logic              present;
  verdict_e          verdict;

  assign wr_diff = {1'b0, in_data_i.port_field} - 6'(PORT_BASE);
  assign wr_rng  = ({1'b0, in_data_i.port_field} >= 6'(PORT_BASE)) &&
                   (wr_diff < 6'(PORT_COUNT));
  assign wr_idx  = wr_rng ? wr_diff[PIDX_W-1:0] : '0;
  assign wr_en   = acc_i && (in_data_i.func == FUNC_PORT_WR) && wr_rng;

  always_comb begin
    logical = lkp_i.dest >= 8'(LOGICAL_BASE);
    pop     = logical ? lkp_i.rt_pop : 1'b1;
    port8   = logical ? {3'b000, lkp_i.rt_port} : lkp_i.dest;
    newlen  = lkp_i.len - {15'd0, pop};
    p_diff  = {1'b0, port8} - 9'(PORT_BASE);
    p_rng   = ({1'b0, port8} >= 9'(PORT_BASE)) && (p_diff < 9'(PORT_COUNT));
    p_idx   = p_rng ? p_diff[PIDX_W-1:0] : '0;
    early   = 1'b1;
    early_v = VERDICT_EMPTY;
    if (lkp_i.len == 16'd0) begin
      early_v = VERDICT_EMPTY;
    end else if ({1'b0, lkp_i.dest} < 9'(PORT_BASE)) begin
      early_v = VERDICT_INVALID;
    end else if (logical && !lkp_i.rt_ok) begin
      early_v = VERDICT_NOROUTE;
    end else begin
      early = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= {in_data_i.entry_enable, in_data_i.port_max_len};
    end
    if (adv_i) begin
      pdata_q   <= mem[p_idx];
      early_q   <= early;
      early_v_q <= early_v;
      port_q    <= port8[4:0];
      newlen_q  <= newlen;
      pop_q     <= pop;
      p_rng_q   <= p_rng;
      more_q    <= lkp_i.more;
      rdy_q     <= p_rng && lkp_i.mask[p_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q  <= '0;
      vld_q      <= 1'b0;
      pent_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[wr_idx] <= 1'b1;
      end
      if (adv_i) begin
        vld_q      <= lkp_i.vld;
        pent_vld_q <= ent_vld_q[p_idx];
      end
    end
  end

  always_comb begin
    present = pent_vld_q && pdata_q[16];
    if (early_q) begin
      verdict = early_v_q;
    end else if (!p_rng_q || !present) begin
      verdict = VERDICT_NOPORT;
    end else if (!rdy_q) begin
      verdict = more_q ? VERDICT_BACKLOG : VERDICT_WAIT;
    end else if (newlen_q > pdata_q[15:0]) begin
      verdict = VERDICT_TOOLONG;
    end else begin
      verdict = VERDICT_FORWARD;
    end
  end

  always_comb begin
    res_vld_o        = vld_q;
    res_o.verdict    = verdict;
    res_o.out_port   = early_q ? 5'd0 : port_q;
    res_o.out_length = early_q ? 16'd0 : newlen_q;
    res_o.popped     = early_q ? 1'b0 : pop_q;
  end

endmodule

`default_nettype wire

@@ rtl/core/packet_route_decision.sv @@
// ----------------------------------------------------------------------------
// Packet route decision
// Decides the fate of a packet from its first byte and length, using a route
// store and a port store that write beats fill.
// ----------------------------------------------------------------------------
//   Channel   Signals                               Direction
//   in        in_valid_i, in_ready_o, in_data_i     packet header or write beat
//   out       out_valid_o, out_ready_i, out_data_o  verdict beat, route beats only
//
// One beat is taken every cycle while the output is not stalled; a verdict
// passes through the route store read, the port store read and the output
// register. Write beats go through the same pipeline and give no result.
// Reset clears the valid bit of every store entry at once, so there is no
// clearing pass. A stalled output holds the whole pipeline and the input.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_route_decision #(
  parameter int unsigned PORT_BASE    = prd_pkg::DEF_PORT_BASE,
  parameter int unsigned PORT_COUNT   = prd_pkg::DEF_PORT_COUNT,
  parameter int unsigned LOGICAL_BASE = prd_pkg::DEF_LOGICAL_BASE,
  parameter int unsigned ROUTE_COUNT  = prd_pkg::DEF_ROUTE_COUNT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire prd_pkg::in_beat_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output prd_pkg::out_beat_t      out_data_o
);
  import prd_pkg::*;

  logic      adv;
  logic      acc;
  lookup_t   lkp;
  logic      res_vld;
  out_beat_t res;
  logic      out_valid_q;
  out_beat_t out_data_q;

  assign adv = !out_valid_q || out_ready_i;
  assign acc = in_valid_i && adv;

  prd_route_lookup #(
    .LOGICAL_BASE(LOGICAL_BASE),
    .ROUTE_COUNT (ROUTE_COUNT)
  ) u_route (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .acc_i    (acc),
    .in_data_i(in_data_i),
    .lkp_o    (lkp)
  );

  prd_port_check #(
    .PORT_BASE   (PORT_BASE),
    .PORT_COUNT  (PORT_COUNT),
    .LOGICAL_BASE(LOGICAL_BASE)
  ) u_port (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .acc_i    (acc),
    .in_data_i(in_data_i),
    .lkp_i    (lkp),
    .res_vld_o(res_vld),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= res;
    end
  end

  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
